// ----- src/sbpr_pkg.sv -----
`default_nettype none

package sbpr_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [8:0] LEN_EXTRA = 9'd4;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [3:0] {
        ST_HDR1 = 4'b0001,
        ST_HDR2 = 4'b0010,
        ST_ID   = 4'b0100,
        ST_BODY = 4'b1000
    } parse_state_t;

    typedef struct packed {
        logic       sum_matches;
        logic [7:0] computed_sum;
        logic [7:0] packet_id;
        logic [8:0] packet_length;
    } result_t;

endpackage

`default_nettype wire

// ----- src/servo_bus_packet_receiver.sv -----
// Servo bus packet receiver.
// The slave channel takes one received serial byte per transaction (s_tdata[7:0]).
// The parser looks for two 0xFF header bytes, an ID byte other than 0xFF and a
// length byte L, then counts L more bytes, the last being the checksum. At the
// end of each packet one transaction leaves on the master channel carrying the
// total length L+4, the ID, the inverted 8-bit sum of ID, length and parameter
// bytes, and a flag that is set when the received checksum equals that sum.
// A length byte of zero ends the packet at once with the flag clear.
// Throughput is one byte per cycle while s_tready is high: the parse state is
// updated in the cycle the byte is taken, and the result is registered into the
// output register, or into the skid register while the output is stalled.
// When the receiver stalls, a second result lands in a one-entry skid register;
// s_tready drops only while that skid register is full, so input keeps flowing
// while one finished result waits.
// A synchronous low aresetn returns the parser to the header search and empties
// the output and skid registers.
`default_nettype none

module servo_bus_packet_receiver
    import sbpr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // [8:0] packet_length, [16:9] packet_id,
                                                   // [24:17] computed_sum, [25] sum_matches
);

    parse_state_t state_reg, state_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [7:0]   sum_reg, sum_next;
    logic [7:0]   id_reg, id_next;

    logic         out_valid_reg;
    result_t      out_data_reg;
    logic         skid_valid_reg;
    result_t      skid_data_reg;

    logic         s_fire;
    logic         res_valid;
    result_t      res_data;
    logic [7:0]   rx_byte;
    logic [7:0]   sum_add;

    assign rx_byte  = s_tdata[7:0];
    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign sum_add  = sum_reg + rx_byte;

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        res_valid  = 1'b0;
        res_data   = '0;
        case (state_reg)
            ST_HDR1: begin
                if (rx_byte == HDR_BYTE) begin
                    state_next = ST_HDR2;
                end else begin
                    state_next = ST_HDR1;
                    len_next   = '0;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
            end
            ST_HDR2: begin
                if (rx_byte == HDR_BYTE) begin
                    state_next = ST_ID;
                end else begin
                    state_next = ST_HDR1;
                    len_next   = '0;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
            end
            ST_ID: begin
                if (rx_byte != HDR_BYTE) begin
                    id_next    = rx_byte;
                    sum_next   = rx_byte;
                    cnt_next   = '0;
                    state_next = ST_BODY;
                end else begin
                    state_next = ST_HDR1;
                    len_next   = '0;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
            end
            ST_BODY: begin
                if (cnt_reg == 8'd0) begin
                    // length byte
                    if (rx_byte == 8'd0) begin
                        res_valid              = 1'b1;
                        res_data.packet_length = LEN_EXTRA;
                        res_data.packet_id     = id_reg;
                        res_data.computed_sum  = ~sum_add;
                        res_data.sum_matches   = 1'b0;
                        state_next = ST_HDR1;
                        len_next   = '0;
                        cnt_next   = '0;
                        sum_next   = '0;
                    end else begin
                        len_next = rx_byte;
                        sum_next = sum_add;
                        cnt_next = 8'd1;
                    end
                end else if (cnt_reg < len_reg) begin
                    sum_next = sum_add;
                    cnt_next = cnt_reg + 8'd1;
                end else begin
                    // checksum byte
                    res_valid              = 1'b1;
                    res_data.packet_length = {1'b0, len_reg} + LEN_EXTRA;
                    res_data.packet_id     = id_reg;
                    res_data.computed_sum  = ~sum_reg;
                    res_data.sum_matches   = (rx_byte == ~sum_reg);
                    state_next = ST_HDR1;
                    len_next   = '0;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
            end
            default: begin
                state_next = ST_HDR1;
                len_next   = '0;
                cnt_next   = '0;
                sum_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HDR1;
            len_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            id_reg    <= '0;
        end else if (s_fire) begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
        end
    end

    // output register with one-entry skid behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg  <= skid_valid_reg || (s_fire && res_valid);
                skid_valid_reg <= 1'b0;
            end else if (s_fire && res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end else if (s_fire && res_valid) begin
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_data_reg};

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_result_from_body: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && res_valid) |-> (state_reg == ST_BODY))
        else $error("result raised outside packet body");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BODY && cnt_reg != 8'd0) |-> (cnt_reg <= len_reg))
        else $error("byte count passed declared length");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_BODY) |-> (cnt_reg == 8'd0))
        else $error("byte count nonzero outside packet body");

endmodule

`default_nettype wire
